/* rtl/wwsm_pkg.sv */
`default_nettype none

package wwsm_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int WLEN_W      = PTR_W + 1;
  localparam int CFG_LEN_W   = 11;
  localparam int SAMPLE_W    = 32;
  localparam int WSUM_W      = 52;
  localparam int PSUM_W      = 42;
  localparam int PROD_W      = SAMPLE_BITS + WLEN_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [PADDR_W-3:0]   REG_WINDOW_LENGTH = '0;
  localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RST = CFG_LEN_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic signed [WSUM_W-1:0] weighted_sum;
    logic signed [WSUM_W-1:0] best_sum;
    logic                     window_full;
    logic                     sequence_done;
    logic                     too_short;
  } out_item_t;

  // one classified request on its way from the front end to the accumulators
  typedef struct packed {
    logic signed [PROD_W-1:0]      product;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic                          steady;
    logic                          full;
    logic                          last;
  } job_t;

endpackage

`default_nettype wire

/* rtl/weighted_window_sum_max.sv */
// Linearly weighted moving sum with running maximum.
// Samples enter on the sample channel (valid/ready); each request gives exactly
// one result on the result channel (valid/ready), in order. The weight runs
// from 1 on the oldest sample to window_length on the newest; window_length is
// written over the APB port at byte address 0 (0 acts as 1, values above 1024
// act as 1024); it must be changed only while the block is idle, which the
// block does not enforce. Throughput: one request per cycle unless the
// result channel stalls, set by the single ring read port and the one 32x11
// front-end multiplier; the accumulator loop closes in an add and a subtract.
// A request marked end_of_sequence is reported, then counters, sums and the
// maximum clear; the sample ring keeps its contents and is not cleared at reset.
// Reset (synchronous) clears the counters, sums, queue and result register and
// sets window_length to 1; the block accepts requests on the next cycle.
// When the receiver stalls, the result register holds, the back end stops, the
// 4-entry queue fills and sample_ready drops after the queue and front stage
// are full; no request is lost.
`default_nettype none

module weighted_window_sum_max (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wwsm_pkg::PADDR_W-1:0]  paddr,
  input  logic [wwsm_pkg::PDATA_W-1:0]  pwdata,
  output logic [wwsm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  wwsm_pkg::in_item_t            sample_item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output wwsm_pkg::out_item_t           result_item
);
  import wwsm_pkg::*;

  logic [CFG_LEN_W-1:0] window_length;
  logic [WLEN_W-1:0]    len;
  logic                 reg_sel;

  logic                 fq_valid;
  logic                 fq_ready;
  job_t                 fq_job;
  logic                 qb_valid;
  logic                 qb_ready;
  job_t                 qb_job;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH;
  assign prdata  = reg_sel ? PDATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_length <= pwdata[CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    if (window_length == '0) begin
      len = WLEN_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len = WLEN_W'(MAX_WINDOW);
    end else begin
      len = WLEN_W'(window_length);
    end
  end

  wwsm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .len          (len),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job          (fq_job)
  );

  wwsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  wwsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (qb_valid),
    .job_ready    (qb_ready),
    .job          (qb_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_sum_zero_until_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.window_full |-> result_item.weighted_sum == '0)
    else $error("weighted sum reported before the window is full");

  a_best_covers_current: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.window_full |->
      result_item.best_sum >= result_item.weighted_sum)
    else $error("best sum below the current complete window");

  a_short_only_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.too_short |->
      result_item.sequence_done && !result_item.window_full)
    else $error("too_short outside a sequence end without a full window");

endmodule

`default_nettype wire

/* rtl/wwsm_front.sv */
`default_nettype none

module wwsm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wwsm_pkg::WLEN_W-1:0]   len,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  wwsm_pkg::in_item_t            sample_item,
  output logic                          job_valid,
  input  logic                          job_ready,
  output wwsm_pkg::job_t                job
);
  import wwsm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  logic [WLEN_W-1:0]             seen;
  logic [PTR_W-1:0]              wp;

  logic                          f1_valid;
  logic signed [SAMPLE_BITS-1:0] f1_sample;
  logic signed [SAMPLE_BITS-1:0] f1_oldest;
  logic [WLEN_W-1:0]             f1_weight;
  logic                          f1_steady;
  logic                          f1_full;
  logic                          f1_last;

  logic                          accept;
  logic                          filling;
  logic [WLEN_W-1:0]             seen_inc;
  logic [PTR_W-1:0]              rd_addr;
  logic [PTR_W-1:0]              wp_inc;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PROD_W-1:0]      product;

  assign x            = sample_item.sample[SAMPLE_BITS-1:0];
  assign sample_ready = !f1_valid || job_ready;
  assign accept       = sample_valid && sample_ready;
  assign filling      = seen < len;
  assign seen_inc     = seen + 1'b1;
  assign wp_inc       = (wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;

  // slot of the sample that leaves the window, modulo the ring depth
  always_comb begin
    if ({1'b0, wp} >= len) begin
      rd_addr = PTR_W'({1'b0, wp} - len);
    end else begin
      rd_addr = PTR_W'({1'b0, wp} + WLEN_W'(MAX_WINDOW) - len);
    end
  end

  // read-first: the oldest sample comes out before this request overwrites its slot
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp]  <= x;
      f1_oldest <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      seen     <= '0;
      wp       <= '0;
    end else begin
      if (sample_ready) begin
        f1_valid <= sample_valid;
      end
      if (accept) begin
        if (sample_item.end_of_sequence) begin
          seen <= '0;
          wp   <= '0;
        end else begin
          if (filling) begin
            seen <= seen_inc;
          end
          wp <= wp_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sample <= x;
      f1_weight <= filling ? seen_inc : len;
      f1_steady <= !filling;
      f1_full   <= !filling || (seen_inc >= len);
      f1_last   <= sample_item.end_of_sequence;
    end
  end

  assign product = PROD_W'(f1_sample) * PROD_W'($signed({1'b0, f1_weight}));

  assign job_valid   = f1_valid;
  assign job.product = product;
  assign job.sample  = f1_sample;
  assign job.oldest  = f1_oldest;
  assign job.steady  = f1_steady;
  assign job.full    = f1_full;
  assign job.last    = f1_last;

endmodule

`default_nettype wire

/* rtl/wwsm_queue.sv */
`default_nettype none

module wwsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  wwsm_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wwsm_pkg::job_t pop_job
);
  import wwsm_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wwsm_back.sv */
`default_nettype none

module wwsm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  wwsm_pkg::job_t      job,
  output logic                result_valid,
  input  logic                result_ready,
  output wwsm_pkg::out_item_t result_item
);
  import wwsm_pkg::*;

  logic signed [WSUM_W-1:0] wsum;
  logic signed [PSUM_W-1:0] psum;
  logic signed [WSUM_W-1:0] wsum_new;
  logic signed [PSUM_W-1:0] psum_new;
  logic signed [WSUM_W-1:0] psum_drop;
  logic signed [PSUM_W-1:0] oldest_drop;

  logic                     a_valid;
  logic signed [WSUM_W-1:0] a_wsum;
  logic                     a_full;
  logic                     a_last;

  logic signed [WSUM_W-1:0] best;
  logic                     best_valid;
  logic signed [WSUM_W-1:0] best_next;
  logic                     best_valid_next;
  logic                     advance;

  // the whole back end moves as one; it holds while the result waits
  assign advance   = !result_valid || result_ready;
  assign job_ready = advance;

  assign psum_drop   = job.steady ? WSUM_W'(psum) : '0;
  assign oldest_drop = job.steady ? PSUM_W'(job.oldest) : '0;
  assign wsum_new    = wsum + WSUM_W'(job.product) - psum_drop;
  assign psum_new    = psum + PSUM_W'(job.sample) - oldest_drop;

  always_comb begin
    best_next       = best;
    best_valid_next = best_valid || a_full;
    if (a_full && (!best_valid || (a_wsum > best))) begin
      best_next = a_wsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
      wsum         <= '0;
      psum         <= '0;
      best         <= '0;
      best_valid   <= 1'b0;
    end else if (advance) begin
      a_valid      <= job_valid;
      result_valid <= a_valid;
      if (job_valid) begin
        wsum <= job.last ? '0 : wsum_new;
        psum <= job.last ? '0 : psum_new;
      end
      if (a_valid) begin
        best       <= a_last ? '0 : best_next;
        best_valid <= a_last ? 1'b0 : best_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (job_valid) begin
        a_wsum <= wsum_new;
        a_full <= job.full;
        a_last <= job.last;
      end
      if (a_valid) begin
        result_item.weighted_sum  <= a_full ? a_wsum : '0;
        result_item.best_sum      <= best_valid_next ? best_next : '0;
        result_item.window_full   <= a_full;
        result_item.sequence_done <= a_last;
        result_item.too_short     <= a_last && !best_valid_next;
      end
    end
  end

endmodule

`default_nettype wire
